// ===== rtl/core/iac_pkg.sv =====
// ----------------------------------------------------------------------------
// iac_pkg
// Shared types and codes of the intrusion alarm controller: word formats,
// configuration set, state, command, zone and register index codes.
// ----------------------------------------------------------------------------
package iac_pkg;

    // State codes
    localparam logic [2:0] ST_DISARMED = 3'd0;
    localparam logic [2:0] ST_ARMING   = 3'd1;
    localparam logic [2:0] ST_ARMED    = 3'd2;
    localparam logic [2:0] ST_ALERT    = 3'd3;
    localparam logic [2:0] ST_ALARM    = 3'd4;
    localparam logic [2:0] ST_COOLDOWN = 3'd5;

    // Command codes
    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_DISARM = 2'd2;
    localparam logic [1:0] OP_RESET  = 2'd3;

    // Zone codes
    localparam logic [1:0] ZONE_EMPTY = 2'd0;
    localparam logic [1:0] ZONE_CLOSE = 2'd1;
    localparam logic [1:0] ZONE_MID   = 2'd2;
    localparam logic [1:0] ZONE_OUTER = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_ARMING_DELAY   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRE_ALARM      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_DURATION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HITS_TO_ALERT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_LOST  = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_ARMING_DELAY   = 32'd30000;
    localparam logic [31:0] RST_PRE_ALARM      = 32'd5000;
    localparam logic [31:0] RST_ALARM_DURATION = 32'd60000;
    localparam logic [31:0] RST_COOLDOWN       = 32'd30000;
    localparam logic [7:0]  RST_HITS_TO_ALERT  = 8'd3;
    localparam logic [31:0] RST_PRESENCE_LOST  = 32'd2000;

    localparam logic [7:0] HIT_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic        detected;
        logic [1:0]  zone;
        logic [15:0] range_cm;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  cur_state;
        logic [2:0]  prior_state;
        logic        alarm_active;
        logic        transitioned;
        logic [1:0]  event_zone;
        logic [15:0] event_range_cm;
        logic [31:0] event_time_ms;
    } out_word_t;

    typedef struct packed {
        logic [31:0] arm_wait_ms;
        logic [31:0] alert_wait_ms;
        logic [31:0] alarm_hold_ms;
        logic [31:0] rest_wait_ms;
        logic [7:0]  hits_to_alert;
        logic [31:0] presence_lost_ms;
    } cfg_t;

endpackage

// ===== rtl/core/intrusion_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// intrusion_alarm_controller_unit
// Six-state intrusion alarm controller driven by radar frame and command words.
// ----------------------------------------------------------------------------
// Takes one input word per clock while in_ready is high and returns exactly one
// result word for each, in order, after it passes the input register and then the
// result register. The whole step (elapsed-time subtract and compare,
// hit counting, next-state choice) sits in the single stage between those two
// registers, so the sustained rate is one word per cycle whenever out_ready
// stays high. When out_ready drops, the pipeline holds and in_ready falls once
// the input register is also full. Configuration registers are written through
// cfg_we / cfg_index / cfg_data; write them only while no word is in flight.
// Indexes beyond the last register are ignored.
module intrusion_alarm_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  iac_pkg::in_word_t                   in_word,

    output logic                                out_valid,
    input  logic                                out_ready,
    output iac_pkg::out_word_t                  out_word,

    input  logic                                cfg_we,
    input  logic [iac_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);

    // Configuration registers
    iac_pkg::cfg_t cfg_reg;

    // Input stage
    logic              s1_valid_reg;
    iac_pkg::in_word_t s1_word_reg;

    // Result stage
    logic               out_valid_reg;
    iac_pkg::out_word_t out_word_reg;

    iac_pkg::out_word_t step_result;
    logic               advance;
    logic               in_fire;

    // The pipeline moves whenever the result register is free or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_wait_ms      <= iac_pkg::RST_ARMING_DELAY;
            cfg_reg.alert_wait_ms    <= iac_pkg::RST_PRE_ALARM;
            cfg_reg.alarm_hold_ms    <= iac_pkg::RST_ALARM_DURATION;
            cfg_reg.rest_wait_ms     <= iac_pkg::RST_COOLDOWN;
            cfg_reg.hits_to_alert    <= iac_pkg::RST_HITS_TO_ALERT;
            cfg_reg.presence_lost_ms <= iac_pkg::RST_PRESENCE_LOST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iac_pkg::REG_ARMING_DELAY:   cfg_reg.arm_wait_ms      <= cfg_data;
                iac_pkg::REG_PRE_ALARM:      cfg_reg.alert_wait_ms    <= cfg_data;
                iac_pkg::REG_ALARM_DURATION: cfg_reg.alarm_hold_ms    <= cfg_data;
                iac_pkg::REG_COOLDOWN:       cfg_reg.rest_wait_ms     <= cfg_data;
                iac_pkg::REG_HITS_TO_ALERT:  cfg_reg.hits_to_alert    <= cfg_data[7:0];
                iac_pkg::REG_PRESENCE_LOST:  cfg_reg.presence_lost_ms <= cfg_data;
                default:                     cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Hold the accepted word until the step stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= in_word;
        end
    end

    // Apply one word to the controller state per advancing cycle
    iac_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_valid_reg && advance),
        .word   (s1_word_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    // Result register: load on advance, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_word_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== rtl/core/iac_core.sv =====
// ----------------------------------------------------------------------------
// iac_core
// Controller state and next-state logic; one word is applied per step.
// ----------------------------------------------------------------------------
module iac_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  iac_pkg::in_word_t word,
    input  iac_pkg::cfg_t     cfg,
    output iac_pkg::out_word_t result
);

    logic [2:0]  mode_reg,          mode_next;
    logic [2:0]  prev_mode_reg,     prev_mode_next;
    logic [31:0] mode_start_reg,    mode_start_next;
    logic [31:0] last_presence_reg, last_presence_next;
    logic [7:0]  hit_count_reg,     hit_count_next;
    logic        alarm_reg,         alarm_next;
    logic [1:0]  rec_zone_reg,      rec_zone_next;
    logic [15:0] rec_dist_reg,      rec_dist_next;
    logic [31:0] rec_time_reg,      rec_time_next;

    logic        go;
    logic        go_frame;
    logic [2:0]  go_state;
    logic [31:0] elapsed;
    logic [31:0] gap;
    logic [7:0]  hit_inc;

    always_comb
    begin
        mode_next          = mode_reg;
        prev_mode_next     = prev_mode_reg;
        mode_start_next    = mode_start_reg;
        last_presence_next = last_presence_reg;
        hit_count_next     = hit_count_reg;
        alarm_next         = alarm_reg;
        rec_zone_next      = rec_zone_reg;
        rec_dist_next      = rec_dist_reg;
        rec_time_next      = rec_time_reg;
        go                 = 1'b0;
        go_frame           = 1'b0;
        go_state           = mode_reg;

        elapsed = word.now_ms - mode_start_reg;
        gap     = word.now_ms - last_presence_reg;
        hit_inc = (hit_count_reg < iac_pkg::HIT_MAX) ? hit_count_reg + 8'd1 : hit_count_reg;

        case (word.opcode)
            iac_pkg::OP_FRAME:
            begin
                case (mode_reg)
                    iac_pkg::ST_ARMING:
                    begin
                        if (elapsed >= cfg.arm_wait_ms)
                        begin
                            go       = 1'b1;
                            go_state = iac_pkg::ST_ARMED;
                        end
                    end
                    iac_pkg::ST_ARMED:
                    begin
                        if (!word.detected)
                        begin
                            hit_count_next = '0;
                        end
                        else
                        begin
                            last_presence_next = word.now_ms;
                            if (word.zone == iac_pkg::ZONE_CLOSE)
                            begin
                                go       = 1'b1;
                                go_frame = 1'b1;
                                go_state = iac_pkg::ST_ALERT;
                            end
                            else if (word.zone == iac_pkg::ZONE_MID ||
                                     word.zone == iac_pkg::ZONE_OUTER)
                            begin
                                if (hit_inc >= cfg.hits_to_alert)
                                begin
                                    hit_count_next = '0;
                                    go             = 1'b1;
                                    go_frame       = 1'b1;
                                    go_state       = iac_pkg::ST_ALERT;
                                end
                                else
                                begin
                                    hit_count_next = hit_inc;
                                end
                            end
                        end
                    end
                    iac_pkg::ST_ALERT:
                    begin
                        if (word.detected)
                        begin
                            last_presence_next = word.now_ms;
                        end
                        // Lost presence wins over the pre-alarm timeout
                        if (!word.detected && gap > cfg.presence_lost_ms)
                        begin
                            go       = 1'b1;
                            go_state = iac_pkg::ST_ARMED;
                        end
                        else if (elapsed >= cfg.alert_wait_ms)
                        begin
                            alarm_next = 1'b1;
                            go         = 1'b1;
                            go_frame   = 1'b1;
                            go_state   = iac_pkg::ST_ALARM;
                        end
                    end
                    iac_pkg::ST_ALARM:
                    begin
                        if (elapsed >= cfg.alarm_hold_ms)
                        begin
                            alarm_next = 1'b0;
                            go         = 1'b1;
                            go_state   = iac_pkg::ST_COOLDOWN;
                        end
                    end
                    iac_pkg::ST_COOLDOWN:
                    begin
                        if (elapsed >= cfg.rest_wait_ms)
                        begin
                            go       = 1'b1;
                            go_state = iac_pkg::ST_ARMED;
                        end
                    end
                    default:
                    begin
                        go = 1'b0;
                    end
                endcase
            end
            iac_pkg::OP_ARM:
            begin
                if (mode_reg == iac_pkg::ST_DISARMED)
                begin
                    go       = 1'b1;
                    go_state = iac_pkg::ST_ARMING;
                end
            end
            iac_pkg::OP_DISARM:
            begin
                if (mode_reg != iac_pkg::ST_DISARMED)
                begin
                    alarm_next = 1'b0;
                    go         = 1'b1;
                    go_state   = iac_pkg::ST_DISARMED;
                end
            end
            default:
            begin
                if (mode_reg == iac_pkg::ST_ALARM || mode_reg == iac_pkg::ST_COOLDOWN)
                begin
                    alarm_next = 1'b0;
                    go         = 1'b1;
                    go_state   = iac_pkg::ST_ARMED;
                end
            end
        endcase

        if (go)
        begin
            prev_mode_next  = mode_reg;
            mode_next       = go_state;
            mode_start_next = word.now_ms;
            rec_zone_next   = go_frame ? word.zone : iac_pkg::ZONE_EMPTY;
            rec_dist_next   = go_frame ? word.range_cm : 16'd0;
            rec_time_next   = word.now_ms;
        end

        result.cur_state      = mode_next;
        result.prior_state    = prev_mode_next;
        result.alarm_active   = alarm_next;
        result.transitioned   = go;
        result.event_zone     = rec_zone_next;
        result.event_range_cm = rec_dist_next;
        result.event_time_ms  = rec_time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= iac_pkg::ST_DISARMED;
            prev_mode_reg     <= iac_pkg::ST_DISARMED;
            mode_start_reg    <= '0;
            last_presence_reg <= '0;
            hit_count_reg     <= '0;
            alarm_reg         <= 1'b0;
            rec_zone_reg      <= iac_pkg::ZONE_EMPTY;
            rec_dist_reg      <= '0;
            rec_time_reg      <= '0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            prev_mode_reg     <= prev_mode_next;
            mode_start_reg    <= mode_start_next;
            last_presence_reg <= last_presence_next;
            hit_count_reg     <= hit_count_next;
            alarm_reg         <= alarm_next;
            rec_zone_reg      <= rec_zone_next;
            rec_dist_reg      <= rec_dist_next;
            rec_time_reg      <= rec_time_next;
        end
    end

endmodule
